// ----- sv/lbps_pkg.sv -----
`timescale 1ns / 1ps

package lbps_pkg;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_START     = 3'd1,
        REQ_STOP      = 3'd2,
        REQ_LOAD      = 3'd3,
        REQ_FORCE_ON  = 3'd4,
        REQ_FORCE_OFF = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        REG_ACTIVE_LEVEL   = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_LOOP_TOTAL     = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic exec;
        logic scan;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } t_dp_stat;

    localparam int LEN_W   = 5;
    localparam int DUR_W   = 16;
    localparam int LOOP_W  = 16;
    localparam int IDX_W   = 4;
    localparam int REQ_W   = 3;

endpackage

// ----- sv/led_blink_pattern_sequencer.sv -----
`timescale 1ns / 1ps
// Result word: registered, valid in the cycle after the input word is accepted; a tick
// that moves to a new step first passes through the prime and scan states, the scan
// skipping zero-length entries. One word at a time: the next input word is taken only
// after the result word is accepted; the pattern table is scanned one entry per cycle.
// Reset (synchronous, active low): sequencer idle, LED dark, registers to defaults.
module led_blink_pattern_sequencer #(
    parameter int PATTERN_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] entry_index, [19:4] entry_duration
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] led_pin, [1] running, [2] done_res, [3] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lbps_pkg::*;

    logic                     r_active_level;
    logic [LEN_W-1:0]         r_pattern_length;
    logic signed [LOOP_W-1:0] r_loop_total;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;
    logic      w_cfg_wr;
    logic      w_lit;
    logic      w_running;
    logic      w_done;
    logic      w_status;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level   <= 1'b1;
            r_pattern_length <= '0;
            r_loop_total     <= -LOOP_W'(1);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_ACTIVE_LEVEL:   r_active_level   <= pwdata[0];
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[LEN_W-1:0];
                REG_LOOP_TOTAL:     r_loop_total     <= pwdata[LOOP_W-1:0];
                default: begin
                    r_active_level <= r_active_level;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ACTIVE_LEVEL:   prdata = {31'd0, r_active_level};
            REG_PATTERN_LENGTH: prdata = {27'd0, r_pattern_length};
            REG_LOOP_TOTAL:     prdata = 32'(r_loop_total);
            default:            prdata = '0;
        endcase
    end

    lbps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    lbps_dp #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_req_type       (s_axis_tuser),
        .i_entry_index    (s_axis_tdata[3:0]),
        .i_entry_duration (s_axis_tdata[19:4]),
        .i_pattern_length (r_pattern_length),
        .i_loop_total     (r_loop_total),
        .o_lit            (w_lit),
        .o_running        (w_running),
        .o_done           (w_done),
        .o_status         (w_status)
    );

    assign m_axis_tdata = {4'd0, w_status, w_done, w_running,
                           w_lit ? r_active_level : ~r_active_level};

endmodule

// ----- sv/lbps_ctrl.sv -----
`timescale 1ns / 1ps

module lbps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  lbps_pkg::t_dp_stat i_stat,
    output lbps_pkg::t_ctrl_cmd o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import lbps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.need_scan ? ST_PRIME : ST_OUT;
                end
            end
            ST_PRIME: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.exec = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/lbps_dp.sv -----
`timescale 1ns / 1ps

module lbps_dp #(
    parameter int PATTERN_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lbps_pkg::t_ctrl_cmd                  i_cmd,
    output lbps_pkg::t_dp_stat                   o_stat,
    input  logic [lbps_pkg::REQ_W-1:0]           i_req_type,
    input  logic [lbps_pkg::IDX_W-1:0]           i_entry_index,
    input  logic [lbps_pkg::DUR_W-1:0]           i_entry_duration,
    input  logic [lbps_pkg::LEN_W-1:0]           i_pattern_length,
    input  logic signed [lbps_pkg::LOOP_W-1:0]   i_loop_total,
    output logic                                 o_lit,
    output logic                                 o_running,
    output logic                                 o_done,
    output logic                                 o_status
);
    import lbps_pkg::*;

    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

    logic [DUR_W-1:0]         r_table [PATTERN_DEPTH];
    logic [DUR_W-1:0]         r_rd_data;

    logic                     r_active, n_active;
    logic [LEN_W-1:0]         r_step,   n_step;
    logic signed [LOOP_W-1:0] r_loops,  n_loops;
    logic [DUR_W-1:0]         r_ticks,  n_ticks;
    logic                     r_lit,    n_lit;
    logic                     r_done,   n_done;
    logic                     r_status, n_status;

    logic [LEN_W-1:0]         w_len;
    logic [DUR_W-1:0]         w_ticks_dec;
    logic                     w_step_in;
    logic                     w_idx_ok;
    logic                     w_wr;
    logic [AW-1:0]            w_wr_addr;
    logic [AW-1:0]            w_rd_addr;

    // effective length: min(pattern_length, depth)
    assign w_len = (32'(i_pattern_length) < 32'(PATTERN_DEPTH)) ?
                   i_pattern_length : LEN_W'(PATTERN_DEPTH);
    assign w_step_in   = (r_step < w_len);
    assign w_idx_ok    = (32'(i_entry_index) < 32'(PATTERN_DEPTH));
    assign w_ticks_dec = (r_ticks != '0) ? (r_ticks - DUR_W'(1)) : '0;
    assign w_wr_addr   = AW'(i_entry_index);
    // read runs one word ahead: address follows the next step index
    assign w_rd_addr   = AW'(n_step);

    always_comb begin
        n_active         = r_active;
        n_step           = r_step;
        n_loops          = r_loops;
        n_ticks          = r_ticks;
        n_lit            = r_lit;
        n_done           = r_done;
        n_status         = r_status;
        w_wr             = 1'b0;
        o_stat.need_scan = 1'b0;
        o_stat.scan_done = !(w_step_in && (r_rd_data == '0));

        if (i_cmd.exec) begin
            n_done   = 1'b0;
            n_status = 1'b0;
            case (i_req_type)
                REQ_TICK: begin
                    if (r_active) begin
                        if (r_loops == '0) begin
                            n_active = 1'b0;
                            n_done   = 1'b1;
                        end else begin
                            n_ticks = w_ticks_dec;
                            o_stat.need_scan = (w_ticks_dec == '0);
                        end
                    end
                end
                REQ_START: begin
                    if (r_active || (w_len == '0)) begin
                        n_status = 1'b1;
                    end else begin
                        n_step   = '0;
                        n_loops  = i_loop_total;
                        n_ticks  = '0;
                        n_active = 1'b1;
                    end
                end
                REQ_STOP: begin
                    n_active = 1'b0;
                end
                REQ_LOAD: begin
                    if (r_active) begin
                        n_status = 1'b1;
                    end else begin
                        w_wr = w_idx_ok;
                    end
                end
                REQ_FORCE_ON: begin
                    n_lit = 1'b1;
                end
                REQ_FORCE_OFF: begin
                    n_lit = 1'b0;
                end
                default: begin
                    n_status = 1'b0;
                end
            endcase
        end

        if (i_cmd.scan) begin
            if (w_step_in) begin
                n_step = r_step + LEN_W'(1);
                if (r_rd_data != '0) begin
                    n_lit   = ~r_step[0];
                    n_ticks = r_rd_data;
                end
            end else begin
                n_step = '0;
                if (r_loops > 0) begin
                    n_loops = r_loops - LOOP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_table[w_wr_addr] <= i_entry_duration;
        end
        r_rd_data <= r_table[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= '0;
            r_loops  <= '0;
            r_ticks  <= '0;
            r_lit    <= 1'b0;
            r_done   <= 1'b0;
            r_status <= 1'b0;
        end else begin
            r_active <= n_active;
            r_step   <= n_step;
            r_loops  <= n_loops;
            r_ticks  <= n_ticks;
            r_lit    <= n_lit;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    assign o_lit     = r_lit;
    assign o_running = r_active;
    assign o_done    = r_done;
    assign o_status  = r_status;

endmodule

// ----- sv/lbps_checker.sv -----
`timescale 1ns / 1ps

module lbps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && !m_axis_tdata[3])
        else $error("done flagged while still running or rejected");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/led_blink_pattern_sequencer_test.sv -----
`timescale 1ns / 1ps

module led_blink_pattern_sequencer_test;

    import lbps_pkg::*;

    localparam int DEPTH         = 16;
    localparam int ITEMS_TARGET  = 1150;
    localparam int QUIET_CYCLES  = 24;
    localparam int LIMIT_CYCLES  = 400000;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // result word, lowest bit first: pin, running, done, status
    typedef struct packed {
        logic status;
        logic done;
        logic running;
        logic pin;
    } t_led_word;

    localparam t_led_word W_IDLE_DARK = 4'b0000;
    localparam t_led_word W_IDLE_LIT  = 4'b0001;
    localparam t_led_word W_REJ_DARK  = 4'b1000;
    localparam t_led_word W_REJ_RUN   = 4'b1011;

    typedef struct {
        bit          is_cfg;
        t_reg        rsel;
        logic [15:0] wval;
        logic [2:0]  req;
        logic [3:0]  idx;
        logic [15:0] dur;
        bit          chk;
        t_led_word   want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // [3:0] entry_index, [19:4] entry_duration
    logic [2:0]  s_axis_tuser = '0;    // [2:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] led_pin, [1] running, [2] done_res, [3] status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    led_blink_pattern_sequencer #(.PATTERN_DEPTH(DEPTH)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sequencer mirror
    logic [15:0]        seq_table [DEPTH];
    logic               seq_on = 1'b0;
    logic               seq_lit = 1'b0;
    int                 seq_step = 0;
    int                 seq_loops = 0;
    int                 seq_ticks = 0;
    logic               cfg_level = 1'b1;
    logic [4:0]         cfg_len = '0;
    logic signed [15:0] cfg_loops = -16'sd1;

    t_led_word led_status_q [$];
    int        fails = 0;
    int        items_sent = 0;
    int        done_seen = 0;
    int        rejects_seen = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        stall_left = 0;
    int        stall_mode = 0;

    function automatic t_led_word predict_led(logic [2:0] req, logic [3:0] idx,
                                              logic [15:0] dur);
        t_led_word w;
        int eff;
        w = '0;
        w.status = STATUS_OK;
        eff = (cfg_len < DEPTH) ? int'(cfg_len) : DEPTH;
        case (req)
            REQ_TICK: begin
                if (seq_on) begin
                    if (seq_loops == 0) begin
                        seq_on = 1'b0;
                        w.done = 1'b1;
                    end else begin
                        if (seq_ticks > 0) seq_ticks--;
                        if (seq_ticks == 0) begin
                            while (seq_step < eff && seq_table[seq_step] == 0) seq_step++;
                            if (seq_step < eff) begin
                                seq_lit = (seq_step % 2 == 0);
                                seq_ticks = seq_table[seq_step];
                                seq_step++;
                            end else begin
                                seq_step = 0;
                                if (seq_loops > 0) seq_loops--;
                            end
                        end
                    end
                end
            end
            REQ_START: begin
                if (seq_on || eff == 0) begin
                    w.status = STATUS_REJECTED;
                end else begin
                    seq_step = 0;
                    seq_loops = int'(cfg_loops);
                    seq_ticks = 0;
                    seq_on = 1'b1;
                end
            end
            REQ_STOP: seq_on = 1'b0;
            REQ_LOAD: begin
                if (seq_on) w.status = STATUS_REJECTED;
                else seq_table[idx] = dur;
            end
            REQ_FORCE_ON:  seq_lit = 1'b1;
            REQ_FORCE_OFF: seq_lit = 1'b0;
            default: ;
        endcase
        w.pin = seq_lit ? cfg_level : ~cfg_level;
        w.running = seq_on;
        return w;
    endfunction

    task automatic push_request(logic [2:0] req, logic [3:0] idx, logic [15:0] dur,
                                bit chk = 1'b0, t_led_word want = '0);
        int gap;
        t_led_word pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {4'b0, dur, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_led(req, idx, dur);
        led_status_q.push_back(chk ? want : pred);
        if (req != REQ_SPARE_A && req != REQ_SPARE_B) items_sent++;
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (led_status_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg rsel, logic [15:0] val);
        logic [31:0] mask;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {rsel, 2'b00};
        pwdata <= {16'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (rsel)
            REG_ACTIVE_LEVEL: begin
                cfg_level = val[0];
                mask = 32'h1;
            end
            REG_PATTERN_LENGTH: begin
                cfg_len = val[4:0];
                mask = 32'h1F;
            end
            default: begin
                cfg_loops = val;
                mask = 32'hFFFF;
            end
        endcase
        if ((prdata & mask) !== ({16'b0, val} & mask)) begin
            $error("%s readback: expected %0h, got %0h", rsel.name(),
                   {16'b0, val} & mask, prdata & mask);
            fails++;
        end
    endtask

    function automatic t_row word_row(logic [2:0] req, logic [3:0] idx, logic [15:0] dur,
                                      bit chk, t_led_word want);
        t_row r;
        r = '{is_cfg: 1'b0, rsel: REG_ACTIVE_LEVEL, wval: '0, req: req, idx: idx,
              dur: dur, chk: chk, want: want};
        return r;
    endfunction

    function automatic t_row cfg_row(t_reg rsel, logic [15:0] val);
        t_row r;
        r = '{is_cfg: 1'b1, rsel: rsel, wval: val, req: REQ_TICK, idx: '0,
              dur: '0, chk: 1'b0, want: '0};
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     led_status_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: modes of always ready, coin flip, sparse and periodic
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (stall_left % 4 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_led_word got;
        t_led_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[3:0];
            if (led_status_q.size() == 0) begin
                $error("result word with nothing expected: %b", got);
                fails++;
            end else begin
                want = led_status_q.pop_front();
                if (got.pin !== want.pin) begin
                    $error("led_pin: expected %b, got %b", want.pin, got.pin);
                    fails++;
                end
                if (got.running !== want.running) begin
                    $error("running: expected %b, got %b", want.running, got.running);
                    fails++;
                end
                if (got.done !== want.done) begin
                    $error("done_res: expected %b, got %b", want.done, got.done);
                    fails++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %b, got %b", want.status, got.status);
                    fails++;
                end
            end
            if (got.done === 1'b1) done_seen++;
            if (got.status === 1'b1) rejects_seen++;
        end
    end

    initial begin
        t_row        dir_rows [$];
        t_row        r;
        int          i;
        int          n;
        int          k;
        int          phase;
        int          pick;
        int          lp;
        logic        lvl;
        logic [4:0]  len;
        logic [15:0] dur;

        for (i = 0; i < DEPTH; i++) seq_table[i] = '0;

        dir_rows.push_back(word_row(REQ_TICK, 4'd0, 16'd0, 1'b1, W_IDLE_DARK));
        dir_rows.push_back(word_row(REQ_START, 4'd0, 16'd0, 1'b1, W_REJ_DARK));
        dir_rows.push_back(word_row(REQ_STOP, 4'd0, 16'd0, 1'b1, W_IDLE_DARK));
        dir_rows.push_back(word_row(REQ_FORCE_ON, 4'd0, 16'd0, 1'b1, W_IDLE_LIT));
        dir_rows.push_back(word_row(REQ_FORCE_OFF, 4'd0, 16'd0, 1'b1, W_IDLE_DARK));
        dir_rows.push_back(word_row(REQ_SPARE_A, 4'hF, 16'hFFFF, 1'b1, W_IDLE_DARK));
        dir_rows.push_back(cfg_row(REG_ACTIVE_LEVEL, 16'd0));
        // active low: lit drives the pin low
        dir_rows.push_back(word_row(REQ_FORCE_ON, 4'd0, 16'd0, 1'b1, W_IDLE_DARK));
        // fill the whole table before anything can read it
        for (i = 0; i < DEPTH; i++) begin
            if (i == 0) dur = 16'd2;
            else if (i == 1 || i == 14) dur = 16'd0;
            else if (i == 15) dur = 16'hFFFF;
            else dur = 16'(i - 1);
            dir_rows.push_back(word_row(REQ_LOAD, 4'(i), dur, 1'b1, W_IDLE_DARK));
        end
        dir_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 16'd3));
        dir_rows.push_back(cfg_row(REG_LOOP_TOTAL, 16'd1));
        dir_rows.push_back(cfg_row(REG_ACTIVE_LEVEL, 16'd1));
        dir_rows.push_back(word_row(REQ_START, 4'd0, 16'd0, 1'b0, '0));
        dir_rows.push_back(word_row(REQ_START, 4'd0, 16'd0, 1'b1, W_REJ_RUN));
        // one pass with a skipped step, the wrap, then the done tick
        for (i = 0; i < 5; i++) dir_rows.push_back(word_row(REQ_TICK, 4'd0, 16'd0, 1'b0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[j]) begin
            r = dir_rows[j];
            if (r.is_cfg) begin
                wait_quiet();
                cfg_write(r.rsel, r.wval);
            end else begin
                push_request(r.req, r.idx, r.dur, r.chk, r.want);
            end
        end

        phase = 0;
        while (items_sent < ITEMS_TARGET) begin
            wait_quiet();
            lvl = $urandom_range(0, 1);
            case (phase)
                0: begin len = 5'd16; lp = -32768; end
                1: begin len = 5'd0;  lp = 0;      end
                2: begin len = 5'd1;  lp = 32767;  end
                default: begin
                    pick = $urandom_range(0, 9);
                    len = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd16 : 5'($urandom_range(1, 6));
                    pick = $urandom_range(0, 9);
                    if (pick <= 5) lp = $urandom_range(0, 3);
                    else if (pick <= 7) lp = -1;
                    else if (pick == 8) lp = -int'($urandom_range(2, 32768));
                    else lp = $urandom_range(4, 32767);
                end
            endcase
            cfg_write(REG_ACTIVE_LEVEL, {15'b0, lvl});
            cfg_write(REG_PATTERN_LENGTH, {11'b0, len});
            cfg_write(REG_LOOP_TOTAL, 16'(lp));

            push_request(REQ_STOP, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
            n = $urandom_range(0, 4);
            for (k = 0; k < n; k++) begin
                dur = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 4));
                push_request(REQ_LOAD, 4'($urandom_range(0, 15)), dur);
            end
            push_request(REQ_START, '0, '0);

            n = $urandom_range(20, 45);
            for (k = 0; k < n; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 82) push_request(REQ_TICK, '0, '0);
                else if (pick < 85) push_request(REQ_FORCE_ON, '0, '0);
                else if (pick < 88) push_request(REQ_FORCE_OFF, '0, '0);
                else if (pick < 91) push_request(REQ_STOP, '0, '0);
                else if (pick < 94) push_request(REQ_START, '0, '0);
                else if (pick < 98)
                    push_request(REQ_LOAD, 4'($urandom_range(0, 15)),
                                 16'($urandom_range(0, 65535)));
                else
                    push_request(pick[0] ? REQ_SPARE_B : REQ_SPARE_A,
                                 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (led_status_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);

        $display("%0d request words over %0d register settings, active high and low",
                 items_sent, phase + 4);
        $display("%0d sequences ran out, %0d requests rejected, %0d cycles",
                 done_seen, rejects_seen, cycle_count);
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/lbps_pkg.sv
sv/lbps_ctrl.sv
sv/lbps_dp.sv
sv/led_blink_pattern_sequencer.sv
sv/lbps_checker.sv
tb/sv/led_blink_pattern_sequencer_test.sv
